@@ rtl/core/qte_pkg.sv @@
// Shared constants, types and the arctangent table for the quaternion-to-Euler block.
`timescale 1ns / 1ps
package qte_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int CORDIC_STAGES = (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;

  localparam int QW = 16;     // quaternion component width
  localparam int PW = 32;     // 16x16 product width
  localparam int TW = 34;     // product-term width (2*(a+b))
  localparam int RW = 58;     // root remainder width
  localparam int ROOT_W = 29; // integer root of a value up to 2^56
  localparam int CW = 38;     // CORDIC x/y width
  localparam int AW = 26;     // CORDIC angle width, 2^-15 degree units
  localparam int LANES = 3;

  localparam int LANE_PITCH = 0;
  localparam int LANE_ROLL = 1;
  localparam int LANE_YAW = 2;

  localparam logic signed [TW-1:0] ONE_Q28 = TW'(64'sd268435456);
  localparam logic signed [TW-1:0] NEG_ONE_Q28 = -ONE_Q28;
  localparam logic [RW-1:0] ONE_Q56 = RW'(1) << 56;
  localparam logic signed [AW-1:0] DEG90 = AW'(90 * 32768);
  localparam logic signed [AW-1:0] DEG180 = AW'(180 * 32768);
  localparam int PITCH_LIM = 11520;
  localparam int ANGLE_LIM = 23040;

  typedef struct packed {
    logic signed [TW-1:0] sp;
    logic signed [TW-1:0] sr;
    logic signed [TW-1:0] cr;
    logic signed [TW-1:0] sy;
    logic signed [TW-1:0] cy;
    logic [RW-1:0]        rem;
    logic                 lock_pos;
    logic                 lock_neg;
  } front_item_t;

  typedef struct packed {
    logic signed [TW-1:0] sp;
    logic signed [TW-1:0] sr;
    logic signed [TW-1:0] cr;
    logic signed [TW-1:0] sy;
    logic signed [TW-1:0] cy;
    logic [ROOT_W-1:0]    root;
    logic                 lock_pos;
    logic                 lock_neg;
  } back_item_t;

  // atan(2^-i) in degrees, scaled by 2^15
  function automatic logic signed [AW-1:0] atan_step(input int i);
    logic signed [AW-1:0] v;
    case (i)
      0: v = AW'(1474560);
      1: v = AW'(870484);
      2: v = AW'(459940);
      3: v = AW'(233473);
      4: v = AW'(117189);
      5: v = AW'(58652);
      6: v = AW'(29333);
      7: v = AW'(14667);
      8: v = AW'(7334);
      9: v = AW'(3667);
      10: v = AW'(1833);
      11: v = AW'(917);
      12: v = AW'(458);
      13: v = AW'(229);
      14: v = AW'(115);
      15: v = AW'(57);
      16: v = AW'(29);
      17: v = AW'(14);
      18: v = AW'(7);
      19: v = AW'(4);
      20: v = AW'(2);
      21: v = AW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/qte_front.sv @@
// Front end: products, sine/cosine terms, gimbal-lock classification and 1 - s^2.
`timescale 1ns / 1ps
module qte_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic signed [qte_pkg::QW-1:0] quat_x,
  input  logic signed [qte_pkg::QW-1:0] quat_y,
  input  logic signed [qte_pkg::QW-1:0] quat_z,
  input  logic signed [qte_pkg::QW-1:0] quat_w,
  output logic                         push,
  output qte_pkg::front_item_t         item
);

  localparam int ROOT_SQ_W = 2 * qte_pkg::ROOT_W;

  logic v1, v2;
  logic signed [qte_pkg::PW-1:0] wx, yz, wy, zx, wz, xy, xx, yy, zz;
  logic signed [qte_pkg::TW-1:0] sp, sr, cr, sy, cy;
  logic signed [ROOT_SQ_W-1:0] sp_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      push <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      push <= v2;
    end
    wx <= quat_w * quat_x;
    yz <= quat_y * quat_z;
    wy <= quat_w * quat_y;
    zx <= quat_z * quat_x;
    wz <= quat_w * quat_z;
    xy <= quat_x * quat_y;
    xx <= quat_x * quat_x;
    yy <= quat_y * quat_y;
    zz <= quat_z * quat_z;
    sr <= (qte_pkg::TW'(wx) + qte_pkg::TW'(yz)) <<< 1;
    sp <= (qte_pkg::TW'(wy) - qte_pkg::TW'(zx)) <<< 1;
    sy <= (qte_pkg::TW'(wz) + qte_pkg::TW'(xy)) <<< 1;
    cr <= qte_pkg::ONE_Q28 - ((qte_pkg::TW'(xx) + qte_pkg::TW'(yy)) <<< 1);
    cy <= qte_pkg::ONE_Q28 - ((qte_pkg::TW'(yy) + qte_pkg::TW'(zz)) <<< 1);
  end

  // only meaningful when |sp| < 1.0, where sp fits the root width
  assign sp_sq = $signed(sp[qte_pkg::ROOT_W-1:0]) * $signed(sp[qte_pkg::ROOT_W-1:0]);

  always_ff @(posedge clk) begin
    item.sp <= sp;
    item.sr <= sr;
    item.cr <= cr;
    item.sy <= sy;
    item.cy <= cy;
    item.rem <= qte_pkg::ONE_Q56 - qte_pkg::RW'(sp_sq);
    item.lock_pos <= (sp >= qte_pkg::ONE_Q28);
    item.lock_neg <= (sp <= qte_pkg::NEG_ONE_Q28);
  end

endmodule

@@ rtl/core/qte_queue.sv @@
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
module qte_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  qte_pkg::front_item_t push_item,
  output logic                 pop,
  output qte_pkg::front_item_t pop_item,
  output logic                 full
);

  qte_pkg::front_item_t mem [0:1];
  logic wptr, rptr;
  logic [1:0] count;

  assign pop = (count != 2'd0);
  assign full = (count == 2'd2);
  assign pop_item = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

endmodule

@@ rtl/core/qte_isqrt.sv @@
// Pipelined integer square root of 1 - s^2, one result bit per stage.
`timescale 1ns / 1ps
module qte_isqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  qte_pkg::front_item_t in_item,
  output logic                 out_valid,
  output qte_pkg::back_item_t  out_item
);

  localparam int N = qte_pkg::ROOT_W;

  logic [qte_pkg::RW-1:0] rem_q [0:N];
  logic [qte_pkg::RW-1:0] res_q [0:N];
  qte_pkg::front_item_t   side_q [0:N];
  logic                   vld_q [0:N];

  assign rem_q[0] = in_item.rem;
  assign res_q[0] = '0;
  assign side_q[0] = in_item;
  assign vld_q[0] = in_valid;

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam logic [qte_pkg::RW-1:0] BIT = qte_pkg::RW'(1) << (2 * (N - 1 - s));
    logic [qte_pkg::RW-1:0] trial;
    logic ge;
    assign trial = res_q[s] + BIT;
    assign ge = (rem_q[s] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
      rem_q[s+1] <= ge ? rem_q[s] - trial : rem_q[s];
      res_q[s+1] <= ge ? (res_q[s] >> 1) + BIT : (res_q[s] >> 1);
      side_q[s+1] <= side_q[s];
    end
  end

  assign out_valid = vld_q[N];
  assign out_item.sp = side_q[N].sp;
  assign out_item.sr = side_q[N].sr;
  assign out_item.cr = side_q[N].cr;
  assign out_item.sy = side_q[N].sy;
  assign out_item.cy = side_q[N].cy;
  assign out_item.root = res_q[N][qte_pkg::ROOT_W-1:0];
  assign out_item.lock_pos = side_q[N].lock_pos;
  assign out_item.lock_neg = side_q[N].lock_neg;

endmodule

@@ rtl/core/qte_cordic.sv @@
// Three-lane pipelined vectoring CORDIC with quadrant fix-up and output rounding.
`timescale 1ns / 1ps
module qte_cordic (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  qte_pkg::back_item_t             in_item,
  output logic                            done,
  output logic signed [14:0]              pitch_deg,
  output logic signed [15:0]              roll_deg,
  output logic signed [15:0]              yaw_deg
);

  localparam int N = qte_pkg::CORDIC_STAGES;
  localparam int L = qte_pkg::LANES;
  localparam int CW = qte_pkg::CW;
  localparam int AW = qte_pkg::AW;
  localparam int OW = AW - 7;

  typedef struct packed {
    logic [L-1:0] zero_y;
    logic [L-1:0] neg_x;
    logic         lock_pos;
    logic         lock_neg;
  } flags_t;

  logic signed [CW-1:0] cx [0:N][0:L-1];
  logic signed [CW-1:0] cy [0:N][0:L-1];
  logic signed [AW-1:0] cz [0:N][0:L-1];
  flags_t               fl [0:N];
  logic                 vld [0:N];

  logic signed [CW-1:0] ys [0:L-1];
  logic signed [CW-1:0] xs [0:L-1];

  assign ys[qte_pkg::LANE_PITCH] = CW'(in_item.sp);
  assign xs[qte_pkg::LANE_PITCH] = CW'($signed({1'b0, in_item.root}));
  assign ys[qte_pkg::LANE_ROLL] = CW'(in_item.sr);
  assign xs[qte_pkg::LANE_ROLL] = CW'(in_item.cr);
  assign ys[qte_pkg::LANE_YAW] = CW'(in_item.sy);
  assign xs[qte_pkg::LANE_YAW] = CW'(in_item.cy);

  // left half-plane: rotate by +/-90 degrees first
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    fl[0].lock_pos <= in_item.lock_pos;
    fl[0].lock_neg <= in_item.lock_neg;
    for (int l = 0; l < L; l++) begin
      fl[0].zero_y[l] <= (ys[l] == '0);
      fl[0].neg_x[l] <= xs[l][CW-1];
      if (xs[l][CW-1]) begin
        if (!ys[l][CW-1]) begin
          cx[0][l] <= ys[l];
          cy[0][l] <= -xs[l];
          cz[0][l] <= qte_pkg::DEG90;
        end else begin
          cx[0][l] <= -ys[l];
          cy[0][l] <= xs[l];
          cz[0][l] <= -qte_pkg::DEG90;
        end
      end else begin
        cx[0][l] <= xs[l];
        cy[0][l] <= ys[l];
        cz[0][l] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [AW-1:0] ATAN = qte_pkg::atan_step(i);
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      fl[i+1] <= fl[i];
      for (int l = 0; l < L; l++) begin
        if (!cy[i][l][CW-1]) begin
          cx[i+1][l] <= cx[i][l] + (cy[i][l] >>> i);
          cy[i+1][l] <= cy[i][l] - (cx[i][l] >>> i);
          cz[i+1][l] <= cz[i][l] + ATAN;
        end else begin
          cx[i+1][l] <= cx[i][l] - (cy[i][l] >>> i);
          cy[i+1][l] <= cy[i][l] + (cx[i][l] >>> i);
          cz[i+1][l] <= cz[i][l] - ATAN;
        end
      end
    end
  end

  // 2^-15 degree to 1/128 degree, ties away from zero, saturated
  function automatic logic signed [OW-1:0] to_out(input logic signed [AW-1:0] a,
                                                  input int lim);
    logic [AW-1:0] m;
    logic [AW-1:0] r;
    logic signed [OW-1:0] lim_s;
    m = a[AW-1] ? -a : a;
    r = (m + AW'(128)) >> 8;
    lim_s = OW'(lim);
    if (r > AW'(lim)) begin
      return a[AW-1] ? -lim_s : lim_s;
    end
    return a[AW-1] ? -$signed(OW'(r)) : $signed(OW'(r));
  endfunction

  logic signed [AW-1:0] ang [0:L-1];
  always_comb begin
    for (int l = 0; l < L; l++) begin
      if (fl[N].zero_y[l]) begin
        ang[l] = fl[N].neg_x[l] ? qte_pkg::DEG180 : '0;
      end else begin
        ang[l] = cz[N][l];
      end
    end
  end

  logic signed [OW-1:0] p_out, r_out, y_out;
  assign p_out = to_out(ang[qte_pkg::LANE_PITCH], qte_pkg::PITCH_LIM);
  assign r_out = to_out(ang[qte_pkg::LANE_ROLL], qte_pkg::ANGLE_LIM);
  assign y_out = to_out(ang[qte_pkg::LANE_YAW], qte_pkg::ANGLE_LIM);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[N];
    end
    if (fl[N].lock_pos) begin
      pitch_deg <= 15'(qte_pkg::PITCH_LIM);
    end else if (fl[N].lock_neg) begin
      pitch_deg <= -15'(qte_pkg::PITCH_LIM);
    end else begin
      pitch_deg <= p_out[14:0];
    end
    roll_deg <= r_out[15:0];
    yaw_deg <= y_out[15:0];
  end

endmodule

@@ rtl/core/quaternion_to_euler_degrees.sv @@
// Top level: quaternion to ZYX Euler angles in 1/128 degree.
`timescale 1ns / 1ps
// Converts a Q2.14 quaternion (x, y, z, w) into pitch, roll and yaw in units
// of 1/128 degree, ZYX convention. A transaction is taken on each clock edge
// with start high and busy low; a new one may follow every cycle. Each result
// appears for exactly one cycle with done high and must be captured then, in
// the order the transactions were taken. The pipeline is 3 front-end stages
// (products, terms, s^2), one queue register, 29 stages of the bit-per-stage
// square root that feeds asin, one quadrant stage, the CORDIC stages and one
// output rounding stage. Pitch saturates to +/-90 degrees on gimbal lock.
// Throughput is one transaction per cycle; busy only reflects a full
// decoupling queue, which the free-running back end never lets happen.
module quaternion_to_euler_degrees (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  output logic               done,
  output logic signed [14:0] pitch_deg,
  output logic signed [15:0] roll_deg,
  output logic signed [15:0] yaw_deg
);

  logic                 accept;
  logic                 push, pop, full;
  qte_pkg::front_item_t push_item, pop_item;
  logic                 root_valid;
  qte_pkg::back_item_t  root_item;

  assign accept = start & ~busy;
  assign busy = full;

  qte_front u_front (
    .clk(clk), .rst(rst), .accept(accept),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
    .push(push), .item(push_item)
  );

  qte_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item),
    .pop(pop), .pop_item(pop_item), .full(full)
  );

  qte_isqrt u_isqrt (
    .clk(clk), .rst(rst), .in_valid(pop), .in_item(pop_item),
    .out_valid(root_valid), .out_item(root_item)
  );

  qte_cordic u_cordic (
    .clk(clk), .rst(rst), .in_valid(root_valid), .in_item(root_item),
    .done(done), .pitch_deg(pitch_deg), .roll_deg(roll_deg), .yaw_deg(yaw_deg)
  );

  // back end drains every cycle, so the queue never fills
  a_never_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue overflow");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (pitch_deg <= 15'sd11520 && pitch_deg >= -15'sd11520))
    else $error("pitch out of range");

  a_roll_yaw_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (roll_deg <= 16'sd23040 && roll_deg >= -16'sd23040 &&
              yaw_deg <= 16'sd23040 && yaw_deg >= -16'sd23040))
    else $error("roll or yaw out of range");

endmodule
